[design/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/plu_pkg.sv]
`timescale 1ns / 1ps

package plu_pkg;

    localparam int VOXEL_W = 32;
    localparam int CFG_W   = 15;
    localparam int SRC_W   = 11;
    localparam int DST_W   = 14;
    localparam int ZOOM_W  = 4;
    localparam int PV_W    = 15;
    localparam int ADDR_W  = 14;
    localparam int SPL_W   = 10;
    localparam int ZPL_W   = 13;
    localparam int K_W     = 3;
    localparam int MAG_W   = 33;
    localparam int REM_W   = 3;

    localparam int PLANE_DEPTH = 16384;

    localparam logic [ZOOM_W-1:0] MAX_ZOOM = 4'd8;
    localparam logic [SRC_W-1:0]  MAX_SRC  = 11'd1024;
    localparam logic [PV_W-1:0]   MAX_PV   = 15'd16384;

    localparam logic [SRC_W-1:0]  RST_SRC  = 11'd1;
    localparam logic [DST_W-1:0]  RST_DST  = 14'd1;
    localparam logic [ZOOM_W-1:0] RST_ZOOM = 4'd1;
    localparam logic [PV_W-1:0]   RST_PV   = 15'd16384;

    // radix-16 divider: 36-bit dividend, one digit per cycle
    localparam int DIV_DIGIT_W = 4;
    localparam int DIV_NUM_W   = 36;
    localparam int DIV_STEPS   = DIV_NUM_W / DIV_DIGIT_W;

    typedef enum logic [1:0] {
        REG_SRC_PLANES   = 2'd0,
        REG_DST_PLANES   = 2'd1,
        REG_ZOOM         = 2'd2,
        REG_PLANE_VOXELS = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

endpackage

[design/plu_ram.sv]
`timescale 1ns / 1ps

module plu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/plu_div.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plu_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [plu_pkg::MAG_W-1:0]    i_dividend,
    input  logic [plu_pkg::ZOOM_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [plu_pkg::MAG_W-1:0]    o_quot,
    output logic [plu_pkg::REM_W-1:0]    o_rem
);

    localparam int NW = plu_pkg::DIV_NUM_W;
    localparam int DW = plu_pkg::DIV_DIGIT_W;
    localparam int ZW = plu_pkg::ZOOM_W;
    localparam int RW = plu_pkg::REM_W;
    localparam int VW = RW + DW;
    localparam int PW = DW + ZW;
    localparam int CW = $clog2(plu_pkg::DIV_STEPS + 1);

    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quot;
    logic [RW-1:0] r_rem;
    logic [ZW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [VW-1:0] w_val;
    logic [DW-1:0] w_digit;
    logic [PW-1:0] w_prod;
    logic [PW-1:0] w_left;

    // one quotient digit per cycle
    always_comb begin
        w_val   = {r_rem, r_num[NW-1 -: DW]};
        w_digit = '0;
        for (int j = 1; j < (1 << DW); j++) begin
            if (PW'(j) * PW'(r_div) <= PW'(w_val)) begin
                w_digit = DW'(j);
            end
        end
        w_prod = PW'(w_digit) * PW'(r_div);
        w_left = PW'(w_val) - w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(plu_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= NW'(i_dividend);
            r_quot <= '0;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_num  <= {r_num[NW-DW-1:0], {DW{1'b0}}};
            r_quot <= {r_quot[NW-DW-1:0], w_digit};
            r_rem  <= w_left[RW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot[plu_pkg::MAG_W-1:0];
    assign o_rem  = r_rem;

    `ASSERT_IMPLIES(a_rem_below_div, i_clk, i_rst_n, r_busy && !i_start, ZW'(r_rem) < r_div, "divider remainder reached divisor")
    `ASSERT_IMPLIES(a_div_nonzero, i_clk, i_rst_n, r_busy && !i_start, r_div != '0, "divider running with zero divisor")

endmodule

[design/plane_linear_upsampler_core.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_voxel_value
// result    out        o_out_valid / i_out_ready  o_out_value, o_out_plane, o_out_index,
//                                                 o_last_of_run
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// a voxel with no result is transferred and then reads the plane store
// pass-through and last-plane-only voxels go from the store read to emission
// interpolating voxels wait for the radix-16 divider, which splits the plane
// difference by zoom in 9 steps, before emission
// synchronous active-low reset clears counters and sets configuration to defaults; store is not cleared
// results leave through an output register; a stalled result holds the sequencer

module plane_linear_upsampler_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [31:0]            i_voxel_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [31:0]            o_out_value,
    output logic [12:0]                   o_out_plane,
    output logic [13:0]                   o_out_index,
    output logic                          o_last_of_run,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [plu_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int VW = plu_pkg::VOXEL_W;
    localparam int SW = plu_pkg::SRC_W;
    localparam int DW = plu_pkg::DST_W;
    localparam int ZW = plu_pkg::ZOOM_W;
    localparam int PW = plu_pkg::PV_W;
    localparam int AW = plu_pkg::ADDR_W;
    localparam int LW = plu_pkg::SPL_W;
    localparam int TW = plu_pkg::ZPL_W;
    localparam int KW = plu_pkg::K_W;
    localparam int MW = plu_pkg::MAG_W;
    localparam int RW = plu_pkg::REM_W;

    plu_pkg::t_state r_state;
    plu_pkg::t_state n_state;

    logic [SW-1:0] r_cfg_src;
    logic [DW-1:0] r_cfg_dst;
    logic [ZW-1:0] r_cfg_zoom;
    logic [PW-1:0] r_cfg_pv;

    logic [AW-1:0] r_pos;
    logic [LW-1:0] r_splane;

    logic [VW-1:0] r_cur;
    logic [VW-1:0] r_prev;
    logic [AW-1:0] r_p;
    logic [LW-1:0] r_s;
    logic          r_neg;
    logic [MW-1:0] r_qstep;
    logic [RW-1:0] r_rstep;
    logic [MW-1:0] r_qacc;
    logic [RW-1:0] r_racc;
    logic [KW-1:0] r_k;
    logic [TW-1:0] r_z;
    logic [VW-1:0] r_a;
    logic          r_phase_a;
    logic          r_single;
    logic          r_has_b;

    logic          r_out_valid;
    logic [VW-1:0] r_out_value;
    logic [TW-1:0] r_out_plane;
    logic [AW-1:0] r_out_index;
    logic          r_out_last;

    logic [SW-1:0] src_eff;
    logic [ZW-1:0] zm_eff;
    logic [PW-1:0] pv_eff;

    logic [AW-1:0] p_eff;
    logic [LW-1:0] s_eff;
    logic [PW-1:0] p_inc;
    logic [SW-1:0] s_inc;

    logic [DW-1:0] zb_full;
    logic [DW-1:0] za_full;
    logic          pass;
    logic          emit_a;
    logic          emit_b;
    logic          has_b;

    logic [MW:0]   diff;
    logic [MW-1:0] mag;
    logic          div_done;
    logic [MW-1:0] div_quot;
    logic [RW-1:0] div_rem;

    logic          accept;
    logic          slot_free;
    logic          load_out;
    logic          start_div;
    logic          go_pass;
    logic          go_b;

    logic [MW+1:0] value_sum;
    logic [DW-1:0] z_inc;
    logic          k_end;
    logic          is_last;
    logic [RW:0]   racc_sum;
    logic          racc_wrap;

    logic [VW-1:0] ram_rdata;

    // configuration clamping
    always_comb begin
        if (r_cfg_src == '0) begin
            src_eff = SW'(1);
        end else if (r_cfg_src > plu_pkg::MAX_SRC) begin
            src_eff = plu_pkg::MAX_SRC;
        end else begin
            src_eff = r_cfg_src;
        end
        if (r_cfg_zoom == '0) begin
            zm_eff = ZW'(1);
        end else if (r_cfg_zoom > plu_pkg::MAX_ZOOM) begin
            zm_eff = plu_pkg::MAX_ZOOM;
        end else begin
            zm_eff = r_cfg_zoom;
        end
        if (r_cfg_pv == '0) begin
            pv_eff = PW'(1);
        end else if (r_cfg_pv > plu_pkg::MAX_PV) begin
            pv_eff = plu_pkg::MAX_PV;
        end else begin
            pv_eff = r_cfg_pv;
        end
    end

    // position counters with restart when past the current limits
    always_comb begin
        p_eff = (PW'(r_pos) >= pv_eff) ? '0 : r_pos;
        s_eff = (SW'(r_splane) >= src_eff) ? '0 : r_splane;
        p_inc = PW'(p_eff) + PW'(1);
        s_inc = SW'(s_eff) + SW'(1);
    end

    // plan for the transferred voxel, valid in S_LOAD
    always_comb begin
        zb_full = DW'(r_s) * DW'(zm_eff);
        za_full = zb_full - DW'(zm_eff);
        pass    = (DW'(src_eff) == r_cfg_dst);
        has_b   = (SW'(r_s) == (src_eff - SW'(1)));
        emit_a  = !pass && (r_s != '0) && (za_full < r_cfg_dst);
        emit_b  = !pass && has_b && (zb_full < r_cfg_dst);
        diff    = (MW+1)'($signed(r_cur)) - (MW+1)'($signed(ram_rdata));
        mag     = diff[MW] ? MW'(-diff) : diff[MW-1:0];
    end

    // emission datapath
    always_comb begin
        value_sum = (MW+2)'($signed(r_a))
                  + (r_neg ? -(MW+2)'(r_qacc) : (MW+2)'(r_qacc));
        z_inc     = DW'(r_z) + DW'(1);
        k_end     = (ZW'(r_k) == (zm_eff - ZW'(1)));
        is_last   = r_single || (z_inc >= r_cfg_dst) || (k_end && !(r_phase_a && r_has_b));
        racc_sum  = (RW+1)'(r_racc) + (RW+1)'(r_rstep);
        racc_wrap = (ZW'(racc_sum) >= zm_eff);
    end

    assign slot_free = !r_out_valid || i_out_ready;

    // sequencer
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        accept     = 1'b0;
        load_out   = 1'b0;
        start_div  = 1'b0;
        go_pass    = 1'b0;
        go_b       = 1'b0;
        case (r_state)
            plu_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    accept  = 1'b1;
                    n_state = plu_pkg::S_LOAD;
                end
            end
            plu_pkg::S_LOAD: begin
                if (pass) begin
                    go_pass = 1'b1;
                    n_state = plu_pkg::S_EMIT;
                end else if (emit_a) begin
                    start_div = 1'b1;
                    n_state   = plu_pkg::S_DIV;
                end else if (emit_b) begin
                    go_b    = 1'b1;
                    n_state = plu_pkg::S_EMIT;
                end else begin
                    n_state = plu_pkg::S_IDLE;
                end
            end
            plu_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = plu_pkg::S_EMIT;
                end
            end
            plu_pkg::S_EMIT: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    if (is_last) begin
                        n_state = plu_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = plu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_src  <= plu_pkg::RST_SRC;
            r_cfg_dst  <= plu_pkg::RST_DST;
            r_cfg_zoom <= plu_pkg::RST_ZOOM;
            r_cfg_pv   <= plu_pkg::RST_PV;
            r_pos      <= '0;
            r_splane   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (plu_pkg::t_cfg_reg'(i_cfg_index))
                    plu_pkg::REG_SRC_PLANES:   r_cfg_src  <= i_cfg_data[SW-1:0];
                    plu_pkg::REG_DST_PLANES:   r_cfg_dst  <= i_cfg_data[DW-1:0];
                    plu_pkg::REG_ZOOM:         r_cfg_zoom <= i_cfg_data[ZW-1:0];
                    plu_pkg::REG_PLANE_VOXELS: r_cfg_pv   <= i_cfg_data[PW-1:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                if (p_inc >= pv_eff) begin
                    r_pos    <= '0;
                    r_splane <= (s_inc >= src_eff) ? '0 : s_inc[LW-1:0];
                end else begin
                    r_pos    <= p_inc[AW-1:0];
                    r_splane <= s_eff;
                end
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur <= i_voxel_value;
            r_p   <= p_eff;
            r_s   <= s_eff;
        end
        if (r_state == plu_pkg::S_LOAD) begin
            r_prev  <= ram_rdata;
            r_has_b <= has_b;
        end
        if (start_div) begin
            r_neg <= diff[MW];
        end
        if (go_pass || go_b) begin
            r_a       <= r_cur;
            r_qstep   <= '0;
            r_rstep   <= '0;
            r_qacc    <= '0;
            r_racc    <= '0;
            r_neg     <= 1'b0;
            r_k       <= '0;
            r_phase_a <= 1'b0;
            r_single  <= go_pass;
            r_z       <= go_pass ? TW'(r_s) : zb_full[TW-1:0];
        end else if (r_state == plu_pkg::S_DIV && div_done) begin
            r_a       <= r_prev;
            r_qstep   <= div_quot;
            r_rstep   <= div_rem;
            r_qacc    <= '0;
            r_racc    <= '0;
            r_k       <= '0;
            r_phase_a <= 1'b1;
            r_single  <= 1'b0;
            r_z       <= za_full[TW-1:0];
        end else if (load_out && !is_last) begin
            r_z <= z_inc[TW-1:0];
            if (k_end) begin
                // switch to the planes of the last source plane
                r_a       <= r_cur;
                r_qstep   <= '0;
                r_rstep   <= '0;
                r_qacc    <= '0;
                r_racc    <= '0;
                r_neg     <= 1'b0;
                r_k       <= '0;
                r_phase_a <= 1'b0;
            end else begin
                r_k    <= r_k + KW'(1);
                r_qacc <= r_qacc + r_qstep + MW'(racc_wrap);
                r_racc <= racc_wrap ? RW'(ZW'(racc_sum) - zm_eff) : racc_sum[RW-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value <= value_sum[VW-1:0];
            r_out_plane <= r_z;
            r_out_index <= r_p;
            r_out_last  <= is_last;
        end
    end

    plu_ram #(
        .WIDTH (VW),
        .DEPTH (plu_pkg::PLANE_DEPTH)
    ) u_plane_store (
        .i_clk   (i_clk),
        .i_we    (r_state == plu_pkg::S_LOAD),
        .i_waddr (r_p),
        .i_wdata (r_cur),
        .i_raddr (p_eff),
        .o_rdata (ram_rdata)
    );

    plu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start_div),
        .i_dividend (mag),
        .i_divisor  (zm_eff),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign o_out_valid   = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_out_plane   = r_out_plane;
    assign o_out_index   = r_out_index;
    assign o_last_of_run = r_out_last;

    `ASSERT_IMPLIES(a_div_done_state, i_clk, i_rst_n, div_done, r_state == plu_pkg::S_DIV, "divider finished outside divide state")
    `ASSERT_IMPLIES(a_plane_in_range, i_clk, i_rst_n, r_state == plu_pkg::S_EMIT, DW'(r_z) < r_cfg_dst, "emitting a suppressed plane")
    `ASSERT_IMPLIES(a_racc_below_zoom, i_clk, i_rst_n, r_state == plu_pkg::S_EMIT, ZW'(r_racc) < zm_eff, "weight remainder reached zoom")
    `ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, r_state == plu_pkg::S_EMIT && slot_free, r_out_valid, "free output slot not filled")

endmodule
